### src/lkcd_pkg.sv
// ----------------------------------------------------------------------------
// lkcd_pkg
// Shared types and codes for the LED and key controller command decoder.
// ----------------------------------------------------------------------------
package lkcd_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_SCAN    = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        PH_CMD    = 4'b0001,
        PH_ADDR   = 4'b0010,
        PH_KEYS   = 4'b0100,
        PH_IGNORE = 4'b1000
    } t_phase;

    // command class, bits 7..6 of the first byte of a frame
    localparam logic [1:0] CLS_NONE = 2'b00;
    localparam logic [1:0] CLS_MODE = 2'b01;
    localparam logic [1:0] CLS_DISP = 2'b10;
    localparam logic [1:0] CLS_ADDR = 2'b11;

    // bit positions inside command bytes
    localparam int MODE_READ_BIT  = 1;
    localparam int MODE_FIXED_BIT = 2;
    localparam int DISP_ON_BIT    = 3;

endpackage

### src/led_key_controller_command_decoder_core.sv
// ----------------------------------------------------------------------------
// led_key_controller_command_decoder_core
// Chip-side decoder for a strobe-framed serial LED and key controller:
// commands, display store writes, key reads and display scan.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_ready  | i_opcode, i_bus_byte, i_key_matrix
//  output  | o_out_valid / i_out_ready| o_read_data ... o_fault (one per beat)
//
//  one beat per cycle while the output is not stalled; each beat passes the input
//  register, then decode and state update into the result register
//  state and store update in the cycle the beat moves from the input register
//  into the result register, so order is kept under any stall pattern
//  synchronous active-low reset clears control state, valid flags and the store
//  a stalled output holds its beat while one more input beat waits in front
// ----------------------------------------------------------------------------
module led_key_controller_command_decoder_core #(
    parameter int STORE_DEPTH = 16,
    parameter int KEY_BYTES   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_bus_byte,
    input  logic [31:0] i_key_matrix,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_store_written,
    output logic [3:0]  o_store_address,
    output logic [7:0]  o_store_value,
    output logic        o_display_enabled,
    output logic [2:0]  o_brightness_level,
    output logic [2:0]  o_grid_index,
    output logic [7:0]  o_grid_segments,
    output logic [7:0]  o_grid_led,
    output logic        o_fault
);
    import lkcd_pkg::*;

    // store kept as segment/LED byte pairs, one row per grid
    localparam int ROWS = (STORE_DEPTH + 1) / 2;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    function automatic logic [3:0] wrap_depth(input logic [3:0] x);
        logic [3:0] v;
        v = x;
        for (int k = 0; k < 8; k++) begin
            if ({1'b0, v} >= 5'(STORE_DEPTH)) begin
                v = v - 4'(STORE_DEPTH);
            end
        end
        return v;
    endfunction

    // input register
    logic        r_in_valid;
    t_opcode     r_in_op;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_keys;

    // control state
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_wptr,   n_wptr;
    logic        r_fixed,  n_fixed;
    logic        r_rmode,  n_rmode;
    logic [2:0]  r_kidx,   n_kidx;
    logic        r_disp,   n_disp;
    logic [2:0]  r_pws,    n_pws;
    logic [2:0]  r_scan,   n_scan;

    logic [7:0]  r_store [ROWS][2];

    // result register
    logic        r_out_valid;
    logic [7:0]  r_rd_data,  n_rd_data;
    logic        r_rd_valid, n_rd_valid;
    logic        r_st_we,    n_st_we;
    logic [3:0]  r_st_addr,  n_st_addr;
    logic [7:0]  r_st_val,   n_st_val;
    logic [2:0]  r_grid,     n_grid;
    logic [7:0]  r_segs,     n_segs;
    logic [7:0]  r_leds,     n_leds;
    logic        r_fault,    n_fault;
    logic        r_disp_out;
    logic [2:0]  r_pws_out;

    logic        advance;
    logic [4:0]  ptr_inc;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign ptr_inc    = {1'b0, r_wptr} + 5'd1;

    always_comb begin
        n_phase    = r_phase;
        n_wptr     = r_wptr;
        n_fixed    = r_fixed;
        n_rmode    = r_rmode;
        n_kidx     = r_kidx;
        n_disp     = r_disp;
        n_pws      = r_pws;
        n_scan     = r_scan;
        n_rd_data  = '0;
        n_rd_valid = 1'b0;
        n_st_we    = 1'b0;
        n_st_addr  = '0;
        n_st_val   = '0;
        n_grid     = '0;
        n_segs     = '0;
        n_leds     = '0;
        n_fault    = 1'b0;

        unique case (r_in_op)
            OP_WRITE: begin
                unique case (r_phase)
                    PH_CMD: begin
                        unique case (r_in_byte[7:6])
                            CLS_MODE: begin
                                n_fixed = r_in_byte[MODE_FIXED_BIT];
                                n_rmode = r_in_byte[MODE_READ_BIT];
                                n_kidx  = '0;
                                n_phase = r_in_byte[MODE_READ_BIT] ? PH_KEYS : PH_IGNORE;
                            end
                            CLS_DISP: begin
                                n_disp  = r_in_byte[DISP_ON_BIT];
                                n_pws   = r_in_byte[2:0];
                                n_phase = PH_IGNORE;
                            end
                            CLS_ADDR: begin
                                n_wptr  = wrap_depth(r_in_byte[3:0]);
                                n_phase = PH_ADDR;
                            end
                            default: begin
                                n_fault = 1'b1;
                                n_phase = PH_IGNORE;
                            end
                        endcase
                    end
                    PH_ADDR: begin
                        n_st_we   = 1'b1;
                        n_st_addr = r_wptr;
                        n_st_val  = r_in_byte;
                        if (!r_fixed) begin
                            n_wptr = (ptr_inc == 5'(STORE_DEPTH)) ? 4'd0 : ptr_inc[3:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                if (r_phase == PH_KEYS && r_rmode && r_kidx < 3'(KEY_BYTES)) begin
                    unique case (r_kidx[1:0])
                        2'd0: n_rd_data = r_in_keys[7:0];
                        2'd1: n_rd_data = r_in_keys[15:8];
                        2'd2: n_rd_data = r_in_keys[23:16];
                        default: n_rd_data = r_in_keys[31:24];
                    endcase
                    n_rd_valid = 1'b1;
                    n_kidx     = r_kidx + 3'd1;
                end else begin
                    n_fault = 1'b1;
                end
            end
            OP_RELEASE: begin
                n_phase = PH_CMD;
                n_kidx  = '0;
            end
            default: begin
                n_grid = r_scan;
                // rows past the store end, and all rows while the display is off, read as blank
                if (r_disp && {1'b0, r_scan} < 4'(ROWS)) begin
                    n_segs = r_store[r_scan[RW-1:0]][0];
                    n_leds = r_store[r_scan[RW-1:0]][1];
                end
                n_scan = r_scan + 3'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_CMD;
            r_wptr      <= '0;
            r_fixed     <= 1'b0;
            r_rmode     <= 1'b0;
            r_kidx      <= '0;
            r_disp      <= 1'b0;
            r_pws       <= '0;
            r_scan      <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_store[r][0] <= '0;
                r_store[r][1] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_wptr  <= n_wptr;
                r_fixed <= n_fixed;
                r_rmode <= n_rmode;
                r_kidx  <= n_kidx;
                r_disp  <= n_disp;
                r_pws   <= n_pws;
                r_scan  <= n_scan;
                if (n_st_we) begin
                    r_store[n_st_addr[RW:1]][n_st_addr[0]] <= n_st_val;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op   <= t_opcode'(i_opcode);
            r_in_byte <= i_bus_byte;
            r_in_keys <= i_key_matrix;
        end
        if (advance) begin
            r_rd_data  <= n_rd_data;
            r_rd_valid <= n_rd_valid;
            r_st_we    <= n_st_we;
            r_st_addr  <= n_st_addr;
            r_st_val   <= n_st_val;
            r_grid     <= n_grid;
            r_segs     <= n_segs;
            r_leds     <= n_leds;
            r_fault    <= n_fault;
            r_disp_out <= n_disp;
            r_pws_out  <= n_pws;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_rd_data;
    assign o_read_valid       = r_rd_valid;
    assign o_store_written    = r_st_we;
    assign o_store_address    = r_st_addr;
    assign o_store_value      = r_st_val;
    assign o_display_enabled  = r_disp_out;
    assign o_brightness_level = r_pws_out;
    assign o_grid_index       = r_grid;
    assign o_grid_segments    = r_segs;
    assign o_grid_led         = r_leds;
    assign o_fault            = r_fault;

    a_read_not_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_fault))
        else $error("read beat flagged as fault");

    a_read_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_store_written))
        else $error("one beat both read keys and wrote the store");

    a_key_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kidx <= 3'(KEY_BYTES))
        else $error("key byte index ran past the last key byte");

    a_store_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_written) |-> ({1'b0, o_store_address} < 5'(STORE_DEPTH)))
        else $error("store write outside the display store");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_SCAN) |=> (r_scan == $past(r_scan) + 3'd1))
        else $error("scan position did not advance on a scan tick");

endmodule
